FILE: rtl/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// shared widths, defaults and the pipeline record for the window max-sum unit
// ----------------------------------------------------------------------------
package wms_pkg;

	localparam int LEN_W           = 9;
	localparam int VAL_W           = 32;
	localparam int SUM_W           = 40;
	localparam int DEF_MAX_WINDOW  = 256;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	// one item leaving the sum stage
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             full;
		logic [SUM_W-1:0] sum;
	} wms_s2_t;

endpackage

FILE: rtl/wms_ring.sv
// ----------------------------------------------------------------------------
// wms_ring
// ring store of recent values, one write and one registered read port
// ----------------------------------------------------------------------------
module wms_ring import wms_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WINDOW,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [VAL_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the old entry when it collides with the write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/wms_sum.sv
// ----------------------------------------------------------------------------
// wms_sum
// ring pointer and fill bookkeeping, ring access and running window sum
// ----------------------------------------------------------------------------
module wms_sum import wms_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  logic [LEN_W-1:0] k,
	input  logic             in_take,
	input  logic [VAL_W-1:0] in_value,
	input  logic             in_last,
	output wms_s2_t          s2
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int DW    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
	localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_WINDOW - 1);

	logic [PTR_W-1:0] ptr_q;
	logic [LEN_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;

	logic [DW-1:0]    diff;
	logic [PTR_W-1:0] src_addr;
	logic             sub_s0;
	logic [LEN_W-1:0] fill_next;
	logic [PTR_W-1:0] ptr_next;

	logic             valid_s1, last_s1, sub_s1, full_s1;
	logic [VAL_W-1:0] value_s1;
	logic [VAL_W-1:0] old_value;
	logic [SUM_W-1:0] sum_new;

	wms_s2_t s2_q;

	// slot written k values ago
	always_comb begin
		diff     = DW'(ptr_q) - DW'(k);
		if (diff[DW-1]) begin
			diff = diff + DW'(MAX_WINDOW);
		end
		src_addr  = diff[PTR_W-1:0];
		sub_s0    = (fill_q >= k);
		fill_next = sub_s0 ? k : fill_q + LEN_W'(1);
		ptr_next  = (ptr_q == PTR_TOP) ? '0 : ptr_q + PTR_W'(1);
	end

	wms_ring #(
		.DEPTH (MAX_WINDOW),
		.AW    (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (in_take),
		.wr_addr (ptr_q),
		.wr_data (in_value),
		.rd_en   (in_take),
		.rd_addr (src_addr),
		.rd_data (old_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
			s2_q     <= '0;
		end else if (clr) begin
			ptr_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (en) begin
			valid_s1   <= in_take;
			s2_q.valid <= valid_s1;
			s2_q.last  <= last_s1;
			s2_q.full  <= full_s1;
			s2_q.sum   <= sum_new;
			if (in_take) begin
				ptr_q  <= in_last ? '0 : ptr_next;
				fill_q <= in_last ? '0 : fill_next;
			end
			if (valid_s1) begin
				sum_q <= last_s1 ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s1  <= in_value;
			last_s1   <= in_last;
			sub_s1    <= sub_s0;
			full_s1   <= (fill_next >= k);
		end
	end

	assign sum_new = sum_q + SUM_W'(signed'(value_s1))
		- (sub_s1 ? SUM_W'(signed'(old_value)) : '0);

	assign s2 = s2_q;

endmodule

FILE: rtl/wms_best.sv
// ----------------------------------------------------------------------------
// wms_best
// best window sum tracking and the result register
// ----------------------------------------------------------------------------
module wms_best import wms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  wms_s2_t          s2,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [SUM_W-1:0] out_sum,
	output logic             out_flag
);

	logic [SUM_W-1:0] best_q;
	logic             best_valid_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_flag_q;

	logic [SUM_W-1:0] best_n;
	logic             best_valid_n;
	logic             emit;

	always_comb begin
		best_n       = best_q;
		best_valid_n = best_valid_q;
		if (s2.valid && s2.full) begin
			if (!best_valid_q || ($signed(s2.sum) > $signed(best_q))) begin
				best_n = s2.sum;
			end
			best_valid_n = 1'b1;
		end
	end

	assign emit = en && s2.valid && s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q       <= '0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr || emit) begin
				best_q       <= '0;
				best_valid_q <= 1'b0;
			end else if (en) begin
				best_q       <= best_n;
				best_valid_q <= best_valid_n;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sum_q  <= best_valid_n ? best_n : '0;
			out_flag_q <= best_valid_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;
	assign out_flag  = out_flag_q;

endmodule

FILE: rtl/window_max_sum_unit.sv
// ----------------------------------------------------------------------------
// window_max_sum_unit
// largest fixed-length window sum over a stream ending in tlast
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)              transaction when
// s_*       in   tdata: value[31:0], tlast: last  s_tvalid & s_tready
// m_*       out  tdata: max_sum[39:0], tuser: ok  m_tvalid & m_tready
// cfg_*     in   cfg_data: window_len[8:0]        cfg_we
//
// one value per cycle while s_tready is high; the ring is read at the
// transaction edge (address from the pointer minus the window length) and written
// at the same edge; the s1, s2 and result registers lie between tlast and m_*
// arst_n clears pointer, fill count, sums and window_len (to 1); ring is not cleared
// s_tready drops only while a finished result waits and the next one is in hand
// ----------------------------------------------------------------------------
module window_max_sum_unit import wms_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // value[31:0]
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // max_sum[39:0]
	output logic             m_tuser,   // valid_res
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data
);

	localparam logic [LEN_W-1:0] MAX_LEN =
		(MAX_WINDOW > 511) ? LEN_W'(511) : LEN_W'(MAX_WINDOW);

	logic [LEN_W-1:0] window_len_q;
	logic [LEN_W-1:0] k;
	logic             en;
	logic             take;
	wms_s2_t          s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			window_len_q <= cfg_data;
		end
	end

	// zero acts as one, oversize saturates
	always_comb begin
		k = window_len_q;
		if (window_len_q == '0) begin
			k = LEN_W'(1);
		end else if (window_len_q > MAX_LEN) begin
			k = MAX_LEN;
		end
	end

	assign en       = !(s2.valid && s2.last && m_tvalid && !m_tready);
	assign s_tready = en;
	assign take     = s_tvalid && en;

	wms_sum #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.clr      (cfg_we),
		.k        (k),
		.in_take  (take),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.s2       (s2)
	);

	wms_best u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.clr       (cfg_we),
		.s2        (s2),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_sum   (m_tdata),
		.out_flag  (m_tuser)
	);

	a_stall_only_on_blocked_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && s2.valid && s2.last))
		else $error("input stalled without a blocked result");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s2.valid && s2.last))
		else $error("result raised without a last item");

	a_no_result_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("empty result carries a nonzero sum");

endmodule
